>>> hw/rtl/tgp_pkg.sv
// ----------------------------------------------------------------------------
// tgp_pkg: shared types and constants for the trilinear grid prolongation
// Grid geometry, field widths and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package tgp_pkg;

    localparam int MAX_COARSE  = 15;
    localparam int GRID_SIDE   = MAX_COARSE + 2;
    localparam int GRID_WORDS  = GRID_SIDE * GRID_SIDE * GRID_SIDE;
    localparam int ADDR_W      = $clog2(GRID_WORDS);
    localparam int SIDE_W      = $clog2(GRID_SIDE);

    localparam int COORD_W     = 6;
    localparam int VALUE_W     = 32;
    localparam int SIZE_W      = 4;
    localparam int SUM_W       = VALUE_W + 3;
    localparam int IN_DATA_W   = 56;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [SIZE_W-1:0] SIZE_RESET  = SIZE_W'(MAX_COARSE);
    localparam logic              REG_SIZE    = 1'b0;
    localparam logic              KIND_LOAD   = 1'b0;
    localparam logic              KIND_QUERY  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_WRITE,
        S_READ,
        S_DRAIN,
        S_EMIT
    } t_state;

endpackage

`default_nettype wire

>>> hw/rtl/trilinear_grid_prolongation.sv
// Throughput: one request at a time; a query steps through all eight corners but reads
// the single-ported coarse grid memory only for the corners it needs; a result left
// waiting downstream stalls the next one.
// Reset: synchronous, active low; clears the sequencer and output valid and
// sets coarse_size to 15. Grid memory contents stay undefined until loaded.
// ----------------------------------------------------------------------------
// trilinear_grid_prolongation
// Stores a coarse 3-D grid and returns trilinear prolongated fine values.
// ----------------------------------------------------------------------------
`default_nettype none

module trilinear_grid_prolongation (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // coord_x, coord_y, coord_z, load_value, zero pad
    input  wire logic [tgp_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // kind
    input  wire logic                              s_axis_tuser,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // fine_value
    output logic [tgp_pkg::VALUE_W-1:0]            m_axis_tdata,
    // range_error
    output logic                                   m_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [tgp_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [tgp_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [tgp_pkg::APB_DATA_W-1:0]         prdata,
    output logic                                   pready
);
    import tgp_pkg::*;

    t_state                      r_state, n_state;
    logic [SIZE_W-1:0]           r_coarse_size;
    logic                        r_kind;
    logic [COORD_W-1:0]          r_cx, r_cy, r_cz;
    logic [VALUE_W-1:0]          r_value;
    logic [2:0]                  r_combo;
    logic                        r_err;
    logic                        r_rd_pend;
    logic signed [SUM_W-1:0]     r_sum;
    logic [VALUE_W-1:0]          r_mem_q;
    logic [VALUE_W-1:0]          r_mem [GRID_WORDS];
    logic [VALUE_W-1:0]          r_out_data;
    logic                        r_out_err;
    logic                        r_out_valid;

    logic                        in_accept;
    logic                        cfg_write;
    logic                        load_err, query_err;
    logic                        combo_ok;
    logic                        mem_we, mem_re;
    logic                        emit_go;
    logic [SIDE_W-1:0]           ax, ay, az;
    logic [ADDR_W-1:0]           mem_addr;
    logic [1:0]                  shift;
    logic [COORD_W:0]            lim_load, lim_query;
    logic [VALUE_W-1:0]          interp;

    assign pready        = 1'b1;
    assign prdata        = APB_DATA_W'(r_coarse_size);
    assign cfg_write     = psel && penable && pwrite && pready && (paddr[2] == REG_SIZE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_err;
    assign m_axis_tvalid = r_out_valid;

    assign lim_load  = (COORD_W+1)'(r_coarse_size) + (COORD_W+1)'(1);
    assign lim_query = (COORD_W+1)'({r_coarse_size, 1'b0}) + (COORD_W+1)'(2);
    assign load_err  = ({1'b0, r_cx} > lim_load) || ({1'b0, r_cy} > lim_load)
                    || ({1'b0, r_cz} > lim_load);
    assign query_err = ({1'b0, r_cx} > lim_query) || ({1'b0, r_cy} > lim_query)
                    || ({1'b0, r_cz} > lim_query);

    assign combo_ok = !((r_combo[0] && !r_cx[0]) || (r_combo[1] && !r_cy[0])
                     || (r_combo[2] && !r_cz[0]));
    assign shift    = 2'(r_cx[0]) + 2'(r_cy[0]) + 2'(r_cz[0]);
    assign interp   = VALUE_W'(r_sum >>> shift);

    always_comb begin
        if (r_kind == KIND_LOAD) begin
            ax = r_cx[SIDE_W-1:0];
            ay = r_cy[SIDE_W-1:0];
            az = r_cz[SIDE_W-1:0];
        end else begin
            ax = SIDE_W'(r_cx[COORD_W-1:1]) + SIDE_W'(r_combo[0]);
            ay = SIDE_W'(r_cy[COORD_W-1:1]) + SIDE_W'(r_combo[1]);
            az = SIDE_W'(r_cz[COORD_W-1:1]) + SIDE_W'(r_combo[2]);
        end
        mem_addr = ADDR_W'(ax) + ADDR_W'(ay) * ADDR_W'(GRID_SIDE)
                 + ADDR_W'(az) * ADDR_W'(GRID_SIDE * GRID_SIDE);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (r_kind == KIND_LOAD) begin
                    n_state = load_err ? S_EMIT : S_WRITE;
                end else begin
                    n_state = query_err ? S_EMIT : S_READ;
                end
            end
            S_WRITE: n_state = S_IDLE;
            S_READ: begin
                if (r_combo == 3'd7) n_state = S_DRAIN;
            end
            S_DRAIN: n_state = S_EMIT;
            S_EMIT: begin
                if (emit_go) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        s_axis_tready = 1'b0;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        emit_go       = 1'b0;
        case (r_state)
            S_IDLE:  s_axis_tready = 1'b1;
            S_WRITE: mem_we        = 1'b1;
            S_READ:  mem_re        = combo_ok;
            S_EMIT:  emit_go       = !r_out_valid || m_axis_tready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_coarse_size <= SIZE_RESET;
            r_out_valid   <= 1'b0;
            r_rd_pend     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_pend <= mem_re;
            if (cfg_write) r_coarse_size <= pwdata[SIZE_W-1:0];
            if (emit_go) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_kind  <= s_axis_tuser;
            r_cx    <= s_axis_tdata[COORD_W-1:0];
            r_cy    <= s_axis_tdata[2*COORD_W-1:COORD_W];
            r_cz    <= s_axis_tdata[3*COORD_W-1:2*COORD_W];
            r_value <= s_axis_tdata[3*COORD_W+VALUE_W-1:3*COORD_W];
        end
        if (r_state == S_CHECK) begin
            r_combo <= 3'd0;
            r_sum   <= '0;
            r_err   <= (r_kind == KIND_LOAD) ? load_err : query_err;
        end else begin
            if (r_state == S_READ) r_combo <= r_combo + 3'd1;
            if (r_rd_pend) r_sum <= r_sum + SUM_W'(signed'(r_mem_q));
        end
        if (emit_go) begin
            r_out_err  <= r_err;
            r_out_data <= r_err ? '0 : interp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_addr] <= r_value;
        if (mem_re) r_mem_q <= r_mem[mem_addr];
    end

`ifndef SYNTHESIS
    a_accept_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_state == S_CHECK)
        else $error("request not followed by range check");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_err) |-> r_out_data == '0)
        else $error("range error with non-zero value");
    a_combo_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ && r_combo != 3'd7) |=>
            (r_state == S_READ && r_combo == $past(r_combo) + 3'd1))
        else $error("read sequence broken");
    a_rose_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_EMIT))
        else $error("result raised outside emit");
    a_no_write_on_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |-> (!r_err && r_kind == KIND_LOAD))
        else $error("store write for bad request");
`endif

endmodule

`default_nettype wire

>>> tb/tb_trilinear_grid_prolongation.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_trilinear_grid_prolongation: self-checking bench for the prolongation
// Loads coarse grid values and queries fine points over several grid sizes.
// A local copy of the coarse grid predicts every result, including range
// errors. Queries only touch coarse points that were loaded before them.
// ----------------------------------------------------------------------------

module tb_trilinear_grid_prolongation;

    import tgp_pkg::*;

    localparam int FIELDS_W      = 3 * COORD_W + VALUE_W;
    localparam int NUM_PHASES    = 9;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT   = 400000;
    localparam logic [APB_ADDR_W-1:0] SIZE_ADDR = APB_ADDR_W'(4 * int'(REG_SIZE));

    typedef struct packed {
        logic               kind;
        logic [VALUE_W-1:0] value;
        logic [COORD_W-1:0] cz;
        logic [COORD_W-1:0] cy;
        logic [COORD_W-1:0] cx;
    } t_grid_req;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               err;
    } t_fine_res;

    logic                    i_clk;
    logic                    i_rst_n = 1'b0;
    // coord_x, coord_y, coord_z, load_value, zero pad
    logic [IN_DATA_W-1:0]    s_axis_tdata = '0;
    // kind
    logic                    s_axis_tuser = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    // fine_value
    logic [VALUE_W-1:0]      m_axis_tdata;
    // range_error
    logic                    m_axis_tuser;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]   paddr = '0;
    logic [APB_DATA_W-1:0]   pwdata = '0;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;

    trilinear_grid_prolongation DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    t_grid_req               pending_req [$];
    t_fine_res               expected_fine [$];

    // predictor state
    logic signed [VALUE_W-1:0] coarse_grid [GRID_WORDS];
    logic [SIZE_W-1:0]       coarse_n = SIZE_RESET;

    // stimulus bookkeeping
    bit                      coarse_written [GRID_WORDS];
    int                      gen_n;
    int                      gen_items;
    bit                      steady_flow;
    logic [SIZE_W-1:0]       size_plan [NUM_PHASES];

    logic                    in_taken = 1'b0;
    logic                    out_taken = 1'b0;
    int                      in_gap;
    int                      out_wait;
    t_grid_req               drive_req;

    t_grid_req               seen_req;
    t_fine_res               want;
    t_fine_res               got;
    int                      eff_n;
    int                      lx, ly, lz;
    logic                    ox, oy, oz;
    logic signed [SUM_W-1:0] sum;

    int                      fail_count;
    int                      n_loads;
    int                      n_queries;
    int                      n_range_err;
    int                      n_checked;
    int                      n_size_writes;
    int                      cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int grid_index(input int x, input int y, input int z);
        return x + GRID_SIDE * (y + GRID_SIDE * z);
    endfunction

    function automatic logic [VALUE_W-1:0] rand_value();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3: return VALUE_W'($urandom_range(0, 15)) - VALUE_W'(8);
            default: return $urandom;
        endcase
    endfunction

    task automatic push_load(input int x, input int y, input int z,
                             input logic [VALUE_W-1:0] v);
        t_grid_req r;
        r.kind  = KIND_LOAD;
        r.cx    = COORD_W'(x);
        r.cy    = COORD_W'(y);
        r.cz    = COORD_W'(z);
        r.value = v;
        pending_req.push_back(r);
        gen_items++;
        if (x <= gen_n + 1 && y <= gen_n + 1 && z <= gen_n + 1)
            coarse_written[grid_index(x, y, z)] = 1'b1;
    endtask

    task automatic push_query(input int x, input int y, input int z);
        t_grid_req r;
        r.kind  = KIND_QUERY;
        r.cx    = COORD_W'(x);
        r.cy    = COORD_W'(y);
        r.cz    = COORD_W'(z);
        r.value = $urandom;
        pending_req.push_back(r);
        gen_items++;
    endtask

    task automatic apb_access(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic settle_block();
        while (pending_req.size() != 0 || s_axis_tvalid || expected_fine.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // request driver and result back-pressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            m_axis_tready <= 1'b0;
            in_gap = 0;
            out_wait = 0;
        end else begin
            if (!s_axis_tvalid || in_taken) begin
                if (in_gap > 0) begin
                    s_axis_tvalid <= 1'b0;
                    in_gap--;
                end else if (pending_req.size() != 0) begin
                    drive_req = pending_req.pop_front();
                    s_axis_tdata  <= IN_DATA_W'({drive_req.value, drive_req.cz,
                                                 drive_req.cy, drive_req.cx});
                    s_axis_tuser  <= drive_req.kind;
                    s_axis_tvalid <= 1'b1;
                    in_gap = steady_flow ? 0 : $urandom_range(0, 3);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            if (out_taken)
                out_wait = steady_flow ? 0 : $urandom_range(0, 3);
            if (out_wait > 0) begin
                m_axis_tready <= 1'b0;
                out_wait--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // predict accepted requests and check results
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_taken  <= 1'b0;
            out_taken <= 1'b0;
            coarse_n = SIZE_RESET;
        end else begin
            in_taken  <= s_axis_tvalid && s_axis_tready;
            out_taken <= m_axis_tvalid && m_axis_tready;

            if (psel && penable && pready && paddr == SIZE_ADDR) begin
                if (pwrite) begin
                    coarse_n = pwdata[SIZE_W-1:0];
                    n_size_writes++;
                end else if (prdata[SIZE_W-1:0] !== coarse_n) begin
                    $display("%0t: coarse_size read mismatch: expected %h actual %h",
                             $time, coarse_n, prdata[SIZE_W-1:0]);
                    fail_count++;
                end
            end

            if (s_axis_tvalid && s_axis_tready) begin
                seen_req = {s_axis_tuser, s_axis_tdata[FIELDS_W-1:0]};
                eff_n = (coarse_n > MAX_COARSE) ? MAX_COARSE : int'(coarse_n);
                want = '{value: '0, err: 1'b1};
                if (seen_req.kind == KIND_LOAD) begin
                    n_loads++;
                    if (seen_req.cx > eff_n + 1 || seen_req.cy > eff_n + 1 ||
                        seen_req.cz > eff_n + 1) begin
                        expected_fine.push_back(want);
                        n_range_err++;
                    end else begin
                        coarse_grid[grid_index(int'(seen_req.cx), int'(seen_req.cy),
                                               int'(seen_req.cz))] = seen_req.value;
                    end
                end else begin
                    n_queries++;
                    if (seen_req.cx > 2 * eff_n + 2 || seen_req.cy > 2 * eff_n + 2 ||
                        seen_req.cz > 2 * eff_n + 2) begin
                        n_range_err++;
                    end else begin
                        ox = seen_req.cx[0];
                        oy = seen_req.cy[0];
                        oz = seen_req.cz[0];
                        lx = int'(seen_req.cx >> 1);
                        ly = int'(seen_req.cy >> 1);
                        lz = int'(seen_req.cz >> 1);
                        sum = '0;
                        for (int d = 0; d < 8; d++) begin
                            if ((d[0] && !ox) || (d[1] && !oy) || (d[2] && !oz))
                                continue;
                            sum += coarse_grid[grid_index(lx + int'(d[0]), ly + int'(d[1]),
                                                          lz + int'(d[2]))];
                        end
                        sum = sum >>> (int'(ox) + int'(oy) + int'(oz));
                        want.value = VALUE_W'(sum);
                        want.err   = 1'b0;
                    end
                    expected_fine.push_back(want);
                end
            end

            if (m_axis_tvalid && m_axis_tready) begin
                got = '{value: m_axis_tdata, err: m_axis_tuser};
                if (expected_fine.size() == 0) begin
                    $display("%0t: result with nothing expected: expected none actual %h/%b",
                             $time, got.value, got.err);
                    fail_count++;
                end else begin
                    want = expected_fine.pop_front();
                    n_checked++;
                    if (got.value !== want.value) begin
                        $display("%0t: fine_value mismatch: expected %h actual %h",
                                 $time, want.value, got.value);
                        fail_count++;
                    end
                    if (got.err !== want.err) begin
                        $display("%0t: range_error mismatch: expected %b actual %b",
                                 $time, want.err, got.err);
                        fail_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     expected_fine.size());
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        int fx, fy, fz;
        int cx, cy, cz;
        int pick, ax, start;
        logic [APB_DATA_W-1:0] wdata;

        size_plan = '{4'd1, 4'd0, 4'd15, 4'd6, 4'd2, 4'd11, 4'd0, 4'd15, 4'd3};
        gen_n = MAX_COARSE;
        steady_flow = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // check the reset size, then hit the top cell of the largest grid
        apb_access(1'b0, SIZE_ADDR, '0);
        push_load(15, 15, 15, 32'h7FFF_FFFF);
        push_load(16, 15, 15, 32'h7FFF_FFFF);
        push_load(15, 16, 15, 32'h8000_0000);
        push_load(16, 16, 15, 32'hFFFF_FFFF);
        push_load(15, 15, 16, 32'h7FFF_FFFF);
        push_load(16, 15, 16, 32'h7FFF_FFFF);
        push_load(15, 16, 16, 32'h7FFF_FFFF);
        push_load(16, 16, 16, 32'h8000_0001);
        push_query(32, 32, 32);
        push_query(31, 30, 30);
        push_query(30, 31, 30);
        push_query(31, 31, 30);
        push_query(31, 31, 31);
        push_query(30, 30, 31);
        push_load(17, 0, 0, 32'h1234_5678);
        push_load(0, 17, 63, 32'hFFFF_FFFF);
        push_load(63, 63, 0, 32'h8000_0000);
        push_query(33, 0, 0);
        push_query(63, 33, 0);
        push_query(0, 0, 63);
        push_load(0, 0, 0, 32'h0000_0000);
        push_query(0, 0, 0);
        settle_block();

        for (int p = 0; p < NUM_PHASES; p++) begin
            steady_flow = (p % 3 == 2);
            wdata = $urandom;
            wdata[SIZE_W-1:0] = size_plan[p];
            apb_access(1'b1, SIZE_ADDR, wdata);
            apb_access(1'b0, SIZE_ADDR, '0);
            gen_n = size_plan[p];
            start = gen_items;
            while (gen_items - start < ITEMS_PER_PHASE) begin
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    fx = $urandom_range(0, 2 * gen_n + 2);
                    fy = $urandom_range(0, 2 * gen_n + 2);
                    fz = $urandom_range(0, 2 * gen_n + 2);
                    // load any corner of the cell not yet written, refresh some
                    for (int d = 0; d < 8; d++) begin
                        if ((d[0] && !fx[0]) || (d[1] && !fy[0]) || (d[2] && !fz[0]))
                            continue;
                        cx = fx / 2 + int'(d[0]);
                        cy = fy / 2 + int'(d[1]);
                        cz = fz / 2 + int'(d[2]);
                        if (!coarse_written[grid_index(cx, cy, cz)] ||
                            $urandom_range(0, 7) == 0)
                            push_load(cx, cy, cz, rand_value());
                    end
                    push_query(fx, fy, fz);
                end else if (pick < 82) begin
                    push_load($urandom_range(0, gen_n + 1), $urandom_range(0, gen_n + 1),
                              $urandom_range(0, gen_n + 1), rand_value());
                end else if (pick < 91) begin
                    ax = $urandom_range(0, 2);
                    fx = (ax == 0) ? $urandom_range(63, gen_n + 2) : $urandom_range(0, 63);
                    fy = (ax == 1) ? $urandom_range(63, gen_n + 2) : $urandom_range(0, 63);
                    fz = (ax == 2) ? $urandom_range(63, gen_n + 2) : $urandom_range(0, 63);
                    push_load(fx, fy, fz, rand_value());
                end else begin
                    ax = $urandom_range(0, 2);
                    fx = (ax == 0) ? $urandom_range(63, 2 * gen_n + 3) : $urandom_range(0, 63);
                    fy = (ax == 1) ? $urandom_range(63, 2 * gen_n + 3) : $urandom_range(0, 63);
                    fz = (ax == 2) ? $urandom_range(63, 2 * gen_n + 3) : $urandom_range(0, 63);
                    push_query(fx, fy, fz);
                end
            end
            settle_block();
        end

        if (expected_fine.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, expected_fine.size());
            fail_count++;
        end
        $display("Covered %0d loads and %0d queries over %0d size writes, sizes 0 to 15;",
                 n_loads, n_queries, n_size_writes);
        $display("%0d results checked, %0d of them range errors.", n_checked, n_range_err);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
